FILE: sv/pts_pkg.sv
package pts_pkg;

	localparam int CoordW = 32;
	localparam int DiffW  = CoordW + 1;        // coordinate difference
	localparam int ProdW  = 2 * DiffW;         // product of two differences
	localparam int DenW   = ProdW;             // |D|^2
	localparam int NumW   = ProdW + 1;         // (Q - P0) . D
	localparam int MagW   = ProdW;             // |num|
	localparam int HalfW  = MagW / 2;
	localparam int PxW    = DiffW + MagW;      // |d| * |num|
	localparam int QuoW   = 35;                // foot offset quotient bits
	localparam int DividW = PxW + 2;           // 2 * |d| * |num| + den
	localparam int DvsW   = DenW + 1;          // 2 * den
	localparam int FootW  = QuoW + 1;          // closest point coordinate
	localparam int ErrW   = FootW + 1;
	localparam int EmagW  = 34;                // |Q - C| per coordinate
	localparam int SqW    = 2 * EmagW;
	localparam int RadW   = 70;                // sum of squares, even width
	localparam int RootW  = RadW / 2;
	localparam int RemW   = RootW + 2;
	localparam int DistW  = 33;

	typedef enum logic [1:0] {
		SEL_FOOT,
		SEL_START,
		SEL_END
	} pts_sel_t;

	typedef struct packed {
		logic signed [CoordW-1:0] query_x;
		logic signed [CoordW-1:0] query_y;
		logic signed [CoordW-1:0] start_x;
		logic signed [CoordW-1:0] start_y;
		logic signed [CoordW-1:0] end_x;
		logic signed [CoordW-1:0] end_y;
		logic                     clamp_to_segment;
		logic                     want_point;
	} pts_in_t;

	typedef struct packed {
		logic [DistW-1:0]         distance;
		logic signed [CoordW-1:0] closest_x;
		logic signed [CoordW-1:0] closest_y;
		logic                     degenerate;
	} pts_out_t;

	typedef struct packed {
		logic signed [CoordW-1:0] qx;
		logic signed [CoordW-1:0] qy;
		logic signed [CoordW-1:0] x0;
		logic signed [CoordW-1:0] y0;
		logic signed [CoordW-1:0] x1;
		logic signed [CoordW-1:0] y1;
		pts_sel_t                 sel;
		logic                     want;
		logic                     degen;
		logic                     negx;
		logic                     negy;
	} pts_side_t;

	typedef struct packed {
		logic [DvsW-1:0] rem;
		logic [QuoW-1:0] num;
		logic [QuoW-1:0] quo;
	} pts_lane_t;

	typedef struct packed {
		pts_lane_t       x;
		pts_lane_t       y;
		logic [DvsW-1:0] dvs;
		pts_side_t       side;
	} pts_div_t;

	typedef struct packed {
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic                     degen;
	} pts_sqside_t;

	typedef struct packed {
		logic [RemW-1:0]  rem;
		logic [RootW-1:0] root;
		logic [RadW-1:0]  rad;
		pts_sqside_t      side;
	} pts_sqrt_t;

endpackage

FILE: sv/pts_div_cell.sv
module pts_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  pts_pkg::pts_div_t din,
	output logic              vout,
	output pts_pkg::pts_div_t dout
);

	logic                              vld_s1;
	pts_pkg::pts_div_t                 step_s1;
	pts_pkg::pts_div_t                 nxt;
	logic [pts_pkg::DvsW:0]            rx;
	logic [pts_pkg::DvsW:0]            ry;
	logic [pts_pkg::DvsW:0]            dv;
	logic                              gex;
	logic                              gey;

	// one quotient bit per lane: bring down the next dividend bit, try to subtract
	always_comb begin
		dv  = {1'b0, din.dvs};
		rx  = {din.x.rem, din.x.num[pts_pkg::QuoW-1]};
		ry  = {din.y.rem, din.y.num[pts_pkg::QuoW-1]};
		gex = rx >= dv;
		gey = ry >= dv;
		nxt = din;
		nxt.x.rem = gex ? pts_pkg::DvsW'(rx - dv) : pts_pkg::DvsW'(rx);
		nxt.y.rem = gey ? pts_pkg::DvsW'(ry - dv) : pts_pkg::DvsW'(ry);
		nxt.x.num = {din.x.num[pts_pkg::QuoW-2:0], 1'b0};
		nxt.y.num = {din.y.num[pts_pkg::QuoW-2:0], 1'b0};
		nxt.x.quo = {din.x.quo[pts_pkg::QuoW-2:0], gex};
		nxt.y.quo = {din.y.quo[pts_pkg::QuoW-2:0], gey};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1 <= nxt;
		end
	end

	assign vout = vld_s1;
	assign dout = step_s1;

endmodule

FILE: sv/pts_sqrt_cell.sv
module pts_sqrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  pts_pkg::pts_sqrt_t din,
	output logic               vout,
	output pts_pkg::pts_sqrt_t dout
);

	logic                     vld_s1;
	pts_pkg::pts_sqrt_t       step_s1;
	pts_pkg::pts_sqrt_t       nxt;
	logic [pts_pkg::RemW+1:0] r2;
	logic [pts_pkg::RemW+1:0] trial;
	logic                     ge;

	// one root bit: bring down two radicand bits, try 4s + 1
	always_comb begin
		r2    = {din.rem, din.rad[pts_pkg::RadW-1 -: 2]};
		trial = {2'b00, din.root, 2'b01};
		ge    = r2 >= trial;
		nxt   = din;
		nxt.rem  = ge ? pts_pkg::RemW'(r2 - trial) : pts_pkg::RemW'(r2);
		nxt.root = {din.root[pts_pkg::RootW-2:0], ge};
		nxt.rad  = {din.rad[pts_pkg::RadW-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1 <= nxt;
		end
	end

	assign vout = vld_s1;
	assign dout = step_s1;

endmodule

FILE: sv/point_to_segment_distance.sv
// Distance from a query point to a line or segment, signed Q16.16 in,
// unsigned Q17.16 distance out, with the closest point and a flag for
// coinciding endpoints.
// Input channel: in_valid / in_ready / in_data, one beat per query.
// Output channel: out_valid / out_ready / out_data, one beat per query,
// in the order the queries were taken.
// Throughput: one beat per cycle, sustained, while out_ready stays high.
// Stages from the accepting edge to out_valid: seven front
// stages (differences, products, sums, clamp decision, offset products),
// a chain of 35 divider cells that settle one quotient bit each for both
// coordinates, four stages that form the point and the squared distance,
// a chain of 35 square-root cells that settle one root bit each, and the
// output register.
// The whole pipeline advances together: when the output register holds a
// beat that is not taken, every stage holds and in_ready falls; bubbles
// travel down the pipeline and are never delivered.
// Reset clears every valid bit at once; the block can take a beat as
// soon as reset is released.
module point_to_segment_distance (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pts_pkg::pts_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output pts_pkg::pts_out_t out_data
);

	logic en;

	// front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	pts_pkg::pts_in_t in_s1, in_s2, in_s3;
	logic signed [pts_pkg::DiffW-1:0] dx_s1, dy_s1, wx_s1, wy_s1;
	logic signed [pts_pkg::DiffW-1:0] dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [pts_pkg::ProdW-1:0] dxx_s2, dyy_s2, nx_s2, ny_s2;
	logic [pts_pkg::DenW-1:0] den_s3, den_s4, den_s5, den_s6;
	logic signed [pts_pkg::NumW-1:0] num_s3;
	logic degen_s3;
	logic [pts_pkg::MagW-1:0] m_s4;
	logic [pts_pkg::DiffW-1:0] adx_s4, ady_s4;
	pts_pkg::pts_side_t side_s4, side_s5, side_s6;
	logic [pts_pkg::ProdW-1:0] pxl_s5, pxh_s5, pyl_s5, pyh_s5;
	logic [pts_pkg::PxW-1:0] px_s6, py_s6;
	pts_pkg::pts_div_t div_s7;

	// combinational helpers
	logic num_neg, num_gt;
	logic signed [pts_pkg::NumW-1:0] num_abs;
	logic signed [pts_pkg::DiffW-1:0] dx_abs, dy_abs;
	pts_pkg::pts_sel_t sel_c;
	logic [pts_pkg::DividW-1:0] nx_c, ny_c;
	pts_pkg::pts_div_t div_s7_next;

	// divider chain
	logic              div_v [0:pts_pkg::QuoW];
	pts_pkg::pts_div_t div_d [0:pts_pkg::QuoW];

	// back stages
	logic v_s8, v_s9, v_s10, v_s11;
	logic signed [pts_pkg::FootW-1:0] cx_s8, cy_s8;
	logic signed [pts_pkg::CoordW-1:0] qx_s8, qy_s8;
	logic want_s8, degen_s8;
	logic signed [pts_pkg::FootW-1:0] sqx, sqy, footx, footy, cx_c, cy_c;
	pts_pkg::pts_div_t div_end;
	logic signed [pts_pkg::ErrW-1:0] ex_c, ey_c, exa_c, eya_c;
	logic [pts_pkg::EmagW-1:0] ex_s9, ey_s9;
	pts_pkg::pts_sqside_t sqs_s9, sqs_s10;
	logic [pts_pkg::SqW-1:0] sxx_s10, syy_s10;
	pts_pkg::pts_sqrt_t sq_s11;

	// root chain
	logic               sq_v [0:pts_pkg::RootW];
	pts_pkg::pts_sqrt_t sq_d [0:pts_pkg::RootW];

	// output
	logic out_valid_q;
	pts_pkg::pts_out_t out_q;
	pts_pkg::pts_out_t out_c;
	pts_pkg::pts_sqrt_t sq_end;
	logic [pts_pkg::RootW:0] rounded;

	function automatic logic signed [pts_pkg::CoordW-1:0] sat32(
		input logic signed [pts_pkg::FootW-1:0] v
	);
		logic signed [pts_pkg::FootW-1:0] hi;
		logic signed [pts_pkg::FootW-1:0] lo;
		hi = pts_pkg::FootW'({1'b0, {(pts_pkg::CoordW-1){1'b1}}});
		lo = -hi - pts_pkg::FootW'(1);
		if (v > hi) begin
			sat32 = hi[pts_pkg::CoordW-1:0];
		end else if (v < lo) begin
			sat32 = lo[pts_pkg::CoordW-1:0];
		end else begin
			sat32 = v[pts_pkg::CoordW-1:0];
		end
	endfunction

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// clamp decision and magnitudes
	always_comb begin
		num_neg = num_s3[pts_pkg::NumW-1];
		num_gt  = num_s3 > $signed({1'b0, den_s3});
		num_abs = num_neg ? -num_s3 : num_s3;
		dx_abs  = dx_s3[pts_pkg::DiffW-1] ? -dx_s3 : dx_s3;
		dy_abs  = dy_s3[pts_pkg::DiffW-1] ? -dy_s3 : dy_s3;
		priority if (degen_s3) begin
			sel_c = pts_pkg::SEL_START;
		end else if (in_s3.clamp_to_segment && num_neg) begin
			sel_c = pts_pkg::SEL_START;
		end else if (in_s3.clamp_to_segment && num_gt) begin
			sel_c = pts_pkg::SEL_END;
		end else begin
			sel_c = pts_pkg::SEL_FOOT;
		end
	end

	// rounded division: (2 |d| |num| + den) / (2 den)
	always_comb begin
		nx_c = {px_s6, 1'b0} + pts_pkg::DividW'(den_s6);
		ny_c = {py_s6, 1'b0} + pts_pkg::DividW'(den_s6);
		div_s7_next.x.rem = pts_pkg::DvsW'(nx_c[pts_pkg::DividW-1:pts_pkg::QuoW]);
		div_s7_next.x.num = nx_c[pts_pkg::QuoW-1:0];
		div_s7_next.x.quo = '0;
		div_s7_next.y.rem = pts_pkg::DvsW'(ny_c[pts_pkg::DividW-1:pts_pkg::QuoW]);
		div_s7_next.y.num = ny_c[pts_pkg::QuoW-1:0];
		div_s7_next.y.quo = '0;
		div_s7_next.dvs   = {den_s6, 1'b0};
		div_s7_next.side  = side_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= in_data;
			dx_s1 <= pts_pkg::DiffW'(in_data.end_x) - pts_pkg::DiffW'(in_data.start_x);
			dy_s1 <= pts_pkg::DiffW'(in_data.end_y) - pts_pkg::DiffW'(in_data.start_y);
			wx_s1 <= pts_pkg::DiffW'(in_data.query_x) - pts_pkg::DiffW'(in_data.start_x);
			wy_s1 <= pts_pkg::DiffW'(in_data.query_y) - pts_pkg::DiffW'(in_data.start_y);

			in_s2  <= in_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dxx_s2 <= pts_pkg::ProdW'(dx_s1) * pts_pkg::ProdW'(dx_s1);
			dyy_s2 <= pts_pkg::ProdW'(dy_s1) * pts_pkg::ProdW'(dy_s1);
			nx_s2  <= pts_pkg::ProdW'(wx_s1) * pts_pkg::ProdW'(dx_s1);
			ny_s2  <= pts_pkg::ProdW'(wy_s1) * pts_pkg::ProdW'(dy_s1);

			in_s3    <= in_s2;
			dx_s3    <= dx_s2;
			dy_s3    <= dy_s2;
			den_s3   <= pts_pkg::DenW'(dxx_s2) + pts_pkg::DenW'(dyy_s2);
			num_s3   <= pts_pkg::NumW'(nx_s2) + pts_pkg::NumW'(ny_s2);
			degen_s3 <= (dx_s2 == '0) && (dy_s2 == '0);

			m_s4          <= num_abs[pts_pkg::MagW-1:0];
			adx_s4        <= dx_abs;
			ady_s4        <= dy_abs;
			den_s4        <= den_s3;
			side_s4.qx    <= in_s3.query_x;
			side_s4.qy    <= in_s3.query_y;
			side_s4.x0    <= in_s3.start_x;
			side_s4.y0    <= in_s3.start_y;
			side_s4.x1    <= in_s3.end_x;
			side_s4.y1    <= in_s3.end_y;
			side_s4.sel   <= sel_c;
			side_s4.want  <= in_s3.want_point;
			side_s4.degen <= degen_s3;
			side_s4.negx  <= num_neg ^ dx_s3[pts_pkg::DiffW-1];
			side_s4.negy  <= num_neg ^ dy_s3[pts_pkg::DiffW-1];

			pxl_s5  <= pts_pkg::ProdW'(adx_s4) * pts_pkg::ProdW'(m_s4[pts_pkg::HalfW-1:0]);
			pxh_s5  <= pts_pkg::ProdW'(adx_s4) * pts_pkg::ProdW'(m_s4[pts_pkg::MagW-1:pts_pkg::HalfW]);
			pyl_s5  <= pts_pkg::ProdW'(ady_s4) * pts_pkg::ProdW'(m_s4[pts_pkg::HalfW-1:0]);
			pyh_s5  <= pts_pkg::ProdW'(ady_s4) * pts_pkg::ProdW'(m_s4[pts_pkg::MagW-1:pts_pkg::HalfW]);
			den_s5  <= den_s4;
			side_s5 <= side_s4;

			px_s6   <= pts_pkg::PxW'({pxh_s5, {pts_pkg::HalfW{1'b0}}}) + pts_pkg::PxW'(pxl_s5);
			py_s6   <= pts_pkg::PxW'({pyh_s5, {pts_pkg::HalfW{1'b0}}}) + pts_pkg::PxW'(pyl_s5);
			den_s6  <= den_s5;
			side_s6 <= side_s5;

			div_s7 <= div_s7_next;
		end
	end

	assign div_v[0] = v_s7;
	assign div_d[0] = div_s7;

	for (genvar i = 0; i < pts_pkg::QuoW; i++) begin : g_div
		pts_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (div_v[i]),
			.din    (div_d[i]),
			.vout   (div_v[i+1]),
			.dout   (div_d[i+1])
		);
	end

	// closest point
	always_comb begin
		div_end = div_d[pts_pkg::QuoW];
		sqx   = pts_pkg::FootW'(div_end.x.quo);
		sqy   = pts_pkg::FootW'(div_end.y.quo);
		footx = pts_pkg::FootW'(div_end.side.x0) + (div_end.side.negx ? -sqx : sqx);
		footy = pts_pkg::FootW'(div_end.side.y0) + (div_end.side.negy ? -sqy : sqy);
		unique case (div_end.side.sel)
			pts_pkg::SEL_START: begin
				cx_c = pts_pkg::FootW'(div_end.side.x0);
				cy_c = pts_pkg::FootW'(div_end.side.y0);
			end
			pts_pkg::SEL_END: begin
				cx_c = pts_pkg::FootW'(div_end.side.x1);
				cy_c = pts_pkg::FootW'(div_end.side.y1);
			end
			pts_pkg::SEL_FOOT: begin
				cx_c = footx;
				cy_c = footy;
			end
			default: begin
				cx_c = footx;
				cy_c = footy;
			end
		endcase
	end

	always_comb begin
		ex_c  = pts_pkg::ErrW'(qx_s8) - pts_pkg::ErrW'(cx_s8);
		ey_c  = pts_pkg::ErrW'(qy_s8) - pts_pkg::ErrW'(cy_s8);
		exa_c = ex_c[pts_pkg::ErrW-1] ? -ex_c : ex_c;
		eya_c = ey_c[pts_pkg::ErrW-1] ? -ey_c : ey_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s8  <= div_v[pts_pkg::QuoW];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s8    <= cx_c;
			cy_s8    <= cy_c;
			qx_s8    <= div_end.side.qx;
			qy_s8    <= div_end.side.qy;
			want_s8  <= div_end.side.want;
			degen_s8 <= div_end.side.degen;

			ex_s9        <= exa_c[pts_pkg::EmagW-1:0];
			ey_s9        <= eya_c[pts_pkg::EmagW-1:0];
			sqs_s9.cx    <= want_s8 ? sat32(cx_s8) : '0;
			sqs_s9.cy    <= want_s8 ? sat32(cy_s8) : '0;
			sqs_s9.degen <= degen_s8;

			sxx_s10 <= pts_pkg::SqW'(ex_s9) * pts_pkg::SqW'(ex_s9);
			syy_s10 <= pts_pkg::SqW'(ey_s9) * pts_pkg::SqW'(ey_s9);
			sqs_s10 <= sqs_s9;

			sq_s11.rem  <= '0;
			sq_s11.root <= '0;
			sq_s11.rad  <= pts_pkg::RadW'(sxx_s10) + pts_pkg::RadW'(syy_s10);
			sq_s11.side <= sqs_s10;
		end
	end

	assign sq_v[0] = v_s11;
	assign sq_d[0] = sq_s11;

	for (genvar j = 0; j < pts_pkg::RootW; j++) begin : g_sqrt
		pts_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (sq_v[j]),
			.din    (sq_d[j]),
			.vout   (sq_v[j+1]),
			.dout   (sq_d[j+1])
		);
	end

	// round to nearest: bump when the remainder exceeds the root, then saturate
	always_comb begin
		sq_end  = sq_d[pts_pkg::RootW];
		rounded = {1'b0, sq_end.root}
			+ (pts_pkg::RootW+1)'(sq_end.rem > pts_pkg::RemW'(sq_end.root));
		if (rounded > (pts_pkg::RootW+1)'({pts_pkg::DistW{1'b1}})) begin
			out_c.distance = {pts_pkg::DistW{1'b1}};
		end else begin
			out_c.distance = rounded[pts_pkg::DistW-1:0];
		end
		out_c.closest_x  = sq_end.side.cx;
		out_c.closest_y  = sq_end.side.cy;
		out_c.degenerate = sq_end.side.degen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sq_v[pts_pkg::RootW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
